@@ hdl/sfr_pkg.sv @@
// Shared types, constants and helpers for the stream find-and-replace block.
package sfr_pkg;

  localparam int PATTERN_MAX     = 16;
  localparam int REPLACEMENT_MAX = 16;
  localparam int CNT_W           = 5;
  localparam int CFG_IDX_W       = 3;
  localparam int CFG_DATA_W      = 64;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PATTERN_LENGTH     = 3'd0,
    REG_PATTERN_LOW        = 3'd1,
    REG_PATTERN_HIGH       = 3'd2,
    REG_REPLACEMENT_LENGTH = 3'd3,
    REG_REPLACEMENT_LOW    = 3'd4,
    REG_REPLACEMENT_HIGH   = 3'd5,
    REG_IGNORE_CASE        = 3'd6
  } sfr_reg_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       is_end;
  } sfr_in_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       has_char;
    logic       last;
  } sfr_out_t;

  typedef enum logic [2:0] {
    OP_NOP        = 3'd0,
    OP_CHAR_HOLD  = 3'd1,
    OP_CHAR_EMIT  = 3'd2,
    OP_CHAR_MATCH = 3'd3,
    OP_END_EMPTY  = 3'd4,
    OP_POP        = 3'd5,
    OP_REPL       = 3'd6
  } sfr_op_t;

  typedef struct packed {
    sfr_op_t op;
    logic    last;
  } sfr_cmd_t;

  typedef struct packed {
    logic out_free;
    logic match;
    logic ins_drop;
    logic ins_more;
    logic pop_more;
    logic win_empty;
    logic win_one;
    logic rlen_zero;
    logic repl_last;
  } sfr_stat_t;

  function automatic logic [7:0] fold(input logic [7:0] c, input logic icase);
    logic [7:0] r;
    r = c;
    if (icase && c >= 8'h41 && c <= 8'h5A) begin
      r = c + 8'h20;
    end
    return r;
  endfunction

endpackage

@@ hdl/sfr_dp.sv @@
// Datapath: configuration registers, character window, compare and output register.
module sfr_dp (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_wr_en,
  input  logic [sfr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [sfr_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  logic [7:0]                       in_ch,
  input  sfr_pkg::sfr_cmd_t                cmd,
  output sfr_pkg::sfr_stat_t               stat,
  input  logic                             out_stall,
  output logic                             out_valid,
  output sfr_pkg::sfr_out_t                out_data
);

  localparam int PM = sfr_pkg::PATTERN_MAX;
  localparam int RM = sfr_pkg::REPLACEMENT_MAX;
  localparam int CW = sfr_pkg::CNT_W;

  logic [CW-1:0]        plen_r;
  logic [8*PM-1:0]      pattern_r;
  logic [CW-1:0]        rlen_r;
  logic [8*RM-1:0]      repl_r;
  logic                 icase_r;

  logic [PM-1:0][7:0]   window_r, window_nxt, win_ins;
  logic [CW-1:0]        count_r, count_nxt;
  logic [3:0]           repl_idx_r, repl_idx_nxt;
  logic                 out_valid_r, out_valid_nxt;
  sfr_pkg::sfr_out_t    out_data_r, out_data_nxt;

  logic [CW-1:0]        plen_eff, rlen_eff, keep, count_inc;
  logic [PM-1:0]        eq, in_pat;
  logic                 match_all;

  always_comb begin
    plen_eff = (plen_r > CW'(PM)) ? CW'(PM) : plen_r;
    rlen_eff = (rlen_r > CW'(RM)) ? CW'(RM) : rlen_r;
    keep      = (plen_eff == '0) ? '0 : plen_eff - CW'(1);
    count_inc = count_r + CW'(1);
    for (int i = 0; i < PM; i++) begin
      win_ins[i] = (count_r == CW'(i)) ? in_ch : window_r[i];
      eq[i]      = sfr_pkg::fold(win_ins[i], icase_r) ==
                   sfr_pkg::fold(pattern_r[8*i +: 8], icase_r);
      in_pat[i]  = CW'(i) < plen_eff;
    end
    match_all = &(eq | ~in_pat);

    stat.out_free  = !out_valid_r || !out_stall;
    stat.match     = (plen_eff != '0) && (count_inc == plen_eff) && match_all;
    stat.ins_drop  = count_inc > keep;
    stat.ins_more  = count_r > keep;
    stat.pop_more  = (count_r - CW'(1)) > keep;
    stat.win_empty = (count_r == '0);
    stat.win_one   = (count_r == CW'(1));
    stat.rlen_zero = (rlen_eff == '0);
    stat.repl_last = (CW'(repl_idx_r) + CW'(1)) >= rlen_eff;
  end

  always_comb begin
    window_nxt    = window_r;
    count_nxt     = count_r;
    repl_idx_nxt  = repl_idx_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    case (cmd.op)
      sfr_pkg::OP_CHAR_HOLD: begin
        window_nxt = win_ins;
        count_nxt  = count_inc;
      end
      sfr_pkg::OP_CHAR_EMIT: begin
        for (int i = 0; i < PM-1; i++) begin
          window_nxt[i] = win_ins[i+1];
        end
        window_nxt[PM-1] = win_ins[PM-1];
        out_valid_nxt    = 1'b1;
        out_data_nxt     = '{out_char: win_ins[0], has_char: 1'b1, last: 1'b0};
      end
      sfr_pkg::OP_CHAR_MATCH: begin
        count_nxt    = '0;
        repl_idx_nxt = '0;
      end
      sfr_pkg::OP_END_EMPTY: begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = '{out_char: 8'h00, has_char: 1'b0, last: 1'b1};
      end
      sfr_pkg::OP_POP: begin
        for (int i = 0; i < PM-1; i++) begin
          window_nxt[i] = window_r[i+1];
        end
        count_nxt     = count_r - CW'(1);
        out_valid_nxt = 1'b1;
        out_data_nxt  = '{out_char: window_r[0], has_char: 1'b1, last: cmd.last};
      end
      sfr_pkg::OP_REPL: begin
        repl_idx_nxt  = repl_idx_r + 4'd1;
        out_valid_nxt = 1'b1;
        out_data_nxt  = '{out_char: repl_r[{repl_idx_r, 3'b000} +: 8],
                          has_char: 1'b1, last: 1'b0};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      plen_r      <= '0;
      pattern_r   <= '0;
      rlen_r      <= '0;
      repl_r      <= '0;
      icase_r     <= 1'b0;
      count_r     <= '0;
      repl_idx_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          sfr_pkg::REG_PATTERN_LENGTH:     plen_r           <= cfg_wdata[CW-1:0];
          sfr_pkg::REG_PATTERN_LOW:        pattern_r[63:0]  <= cfg_wdata;
          sfr_pkg::REG_PATTERN_HIGH:       pattern_r[127:64] <= cfg_wdata;
          sfr_pkg::REG_REPLACEMENT_LENGTH: rlen_r           <= cfg_wdata[CW-1:0];
          sfr_pkg::REG_REPLACEMENT_LOW:    repl_r[63:0]     <= cfg_wdata;
          sfr_pkg::REG_REPLACEMENT_HIGH:   repl_r[127:64]   <= cfg_wdata;
          sfr_pkg::REG_IGNORE_CASE:        icase_r          <= cfg_wdata[0];
          default: begin
          end
        endcase
      end
      count_r     <= count_nxt;
      repl_idx_r  <= repl_idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    window_r   <= window_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r < CW'(PM))
    else $error("window count out of range");

  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == sfr_pkg::OP_CHAR_EMIT || cmd.op == sfr_pkg::OP_POP ||
     cmd.op == sfr_pkg::OP_REPL || cmd.op == sfr_pkg::OP_END_EMPTY) |-> stat.out_free)
    else $error("beat loaded while output register busy");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.op == sfr_pkg::OP_POP |-> count_r != '0)
    else $error("pop from empty window");

  a_repl_len: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.op == sfr_pkg::OP_REPL |-> CW'(repl_idx_r) < rlen_eff)
    else $error("replacement index past length");

endmodule

@@ hdl/sfr_ctrl.sv @@
// Controller: sequences accept, drain, replacement and end flush.
module sfr_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_is_end,
  output logic               in_stall,
  input  sfr_pkg::sfr_stat_t stat,
  output sfr_pkg::sfr_cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_DRAIN = 4'b0010,
    S_FLUSH = 4'b0100,
    S_REPL  = 4'b1000
  } sfr_state_t;

  sfr_state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '{op: sfr_pkg::OP_NOP, last: 1'b0};
    in_stall  = !((state_r == S_IDLE) && stat.out_free);
    case (state_r)
      S_IDLE: begin
        if (in_valid && stat.out_free) begin
          if (in_is_end) begin
            if (stat.win_empty) begin
              cmd.op = sfr_pkg::OP_END_EMPTY;
            end else begin
              cmd.op   = sfr_pkg::OP_POP;
              cmd.last = stat.win_one;
              if (!stat.win_one) state_nxt = S_FLUSH;
            end
          end else if (stat.match) begin
            cmd.op = sfr_pkg::OP_CHAR_MATCH;
            if (!stat.rlen_zero) state_nxt = S_REPL;
          end else if (stat.ins_drop) begin
            cmd.op = sfr_pkg::OP_CHAR_EMIT;
            if (stat.ins_more) state_nxt = S_DRAIN;
          end else begin
            cmd.op = sfr_pkg::OP_CHAR_HOLD;
          end
        end
      end
      S_DRAIN: begin
        if (stat.out_free) begin
          cmd.op = sfr_pkg::OP_POP;
          if (!stat.pop_more) state_nxt = S_IDLE;
        end
      end
      S_FLUSH: begin
        if (stat.out_free) begin
          cmd.op   = sfr_pkg::OP_POP;
          cmd.last = stat.win_one;
          if (stat.win_one) state_nxt = S_IDLE;
        end
      end
      S_REPL: begin
        if (stat.out_free) begin
          cmd.op = sfr_pkg::OP_REPL;
          if (stat.repl_last) state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

@@ hdl/stream_find_replace.sv @@
// Top level of the streaming find-and-replace block.
// One character beat is taken per cycle while the output side keeps up and no
// match completes: a character that fills the window without a match either
// waits in the window or pushes the oldest character out in the same cycle.
// A completed match whose replacement has R bytes holds the input while those R
// bytes are sent. An end beat that finds N characters in the window holds it while
// the rest are sent; an end beat on an empty window gives one end marker and holds
// nothing. Every result passes
// through a single output register, one beat per cycle, so a stalled output side
// also stalls the input. After a shorter pattern length is written mid-string,
// the next character may push several older characters out, one per cycle while the output side keeps up.
module stream_find_replace (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic [sfr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sfr_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  sfr_pkg::sfr_in_t               in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output sfr_pkg::sfr_out_t              out_data
);

  sfr_pkg::sfr_cmd_t  cmd;
  sfr_pkg::sfr_stat_t stat;

  sfr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_is_end (in_data.is_end),
    .in_stall  (in_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  sfr_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_data.ch),
    .cmd       (cmd),
    .stat      (stat),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

@@ tb/sv/tb_stream_find_replace.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for stream_find_replace: directed and random text against a predictor.
module tb_stream_find_replace;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 40;
  localparam int HOLD_CYCLES    = 400;
  localparam int PHASES         = 6;
  localparam int PHASE_ITEMS    = 22;

  class edit_stream;
    logic [4:0]        pat_len;
    logic [4:0]        rep_len;
    logic [63:0]       pat_lo;
    logic [63:0]       pat_hi;
    logic [63:0]       rep_lo;
    logic [63:0]       rep_hi;
    logic              fold_case;
    logic [7:0]        win [sfr_pkg::PATTERN_MAX];
    int                win_cnt;
    sfr_pkg::sfr_out_t text_due [$];
    int                errors;

    function new();
      pat_len   = '0;
      rep_len   = '0;
      pat_lo    = '0;
      pat_hi    = '0;
      rep_lo    = '0;
      rep_hi    = '0;
      fold_case = 1'b0;
      win_cnt   = 0;
      errors    = 0;
    endfunction

    function void write_reg(sfr_pkg::sfr_reg_t idx, logic [63:0] v);
      case (idx)
        sfr_pkg::REG_PATTERN_LENGTH:     pat_len = v[4:0];
        sfr_pkg::REG_PATTERN_LOW:        pat_lo = v;
        sfr_pkg::REG_PATTERN_HIGH:       pat_hi = v;
        sfr_pkg::REG_REPLACEMENT_LENGTH: rep_len = v[4:0];
        sfr_pkg::REG_REPLACEMENT_LOW:    rep_lo = v;
        sfr_pkg::REG_REPLACEMENT_HIGH:   rep_hi = v;
        sfr_pkg::REG_IGNORE_CASE:        fold_case = v[0];
        default: ;
      endcase
    endfunction

    function logic [7:0] lower(logic [7:0] c);
      if (fold_case && c >= "A" && c <= "Z") begin
        return c + 8'd32;
      end
      return c;
    endfunction

    function logic [7:0] byte_at(logic [63:0] lo, logic [63:0] hi, int i);
      return (i < 8) ? lo[8*i +: 8] : hi[8*(i-8) +: 8];
    endfunction

    function void emit(logic [7:0] c, logic h, logic l);
      sfr_pkg::sfr_out_t r;
      r.out_char = c;
      r.has_char = h;
      r.last     = l;
      text_due.push_back(r);
    endfunction

    function void accept_char(sfr_pkg::sfr_in_t beat);
      int plen;
      int rlen;
      int keep;
      int drop;
      bit hit;
      plen = (pat_len > sfr_pkg::PATTERN_MAX) ? sfr_pkg::PATTERN_MAX : int'(pat_len);
      if (beat.is_end) begin
        if (win_cnt == 0) begin
          emit(8'h00, 1'b0, 1'b1);
        end
        for (int i = 0; i < win_cnt; i++) begin
          emit(win[i], 1'b1, i == win_cnt - 1);
        end
        win_cnt = 0;
        return;
      end
      win[win_cnt] = beat.ch;
      win_cnt++;
      if (plen > 0 && win_cnt == plen) begin
        hit = 1'b1;
        for (int i = 0; i < plen; i++) begin
          if (lower(win[i]) != lower(byte_at(pat_lo, pat_hi, i))) begin
            hit = 1'b0;
          end
        end
        if (hit) begin
          rlen = (rep_len > sfr_pkg::REPLACEMENT_MAX) ? sfr_pkg::REPLACEMENT_MAX
                                                      : int'(rep_len);
          for (int i = 0; i < rlen; i++) begin
            emit(byte_at(rep_lo, rep_hi, i), 1'b1, 1'b0);
          end
          win_cnt = 0;
          return;
        end
      end
      keep = (plen > 0) ? plen - 1 : 0;
      if (win_cnt > keep) begin
        drop = win_cnt - keep;
        for (int i = 0; i < drop; i++) begin
          emit(win[i], 1'b1, 1'b0);
        end
        for (int i = 0; i < keep; i++) begin
          win[i] = win[i + drop];
        end
        win_cnt = keep;
      end
    endfunction

    function void check_char(sfr_pkg::sfr_out_t got);
      sfr_pkg::sfr_out_t want;
      if (text_due.size() == 0) begin
        $error("unexpected result beat: %h", got);
        errors++;
        return;
      end
      want = text_due.pop_front();
      if (got.out_char !== want.out_char) begin
        $error("out_char: expected %h, got %h", want.out_char, got.out_char);
        errors++;
      end
      if (got.has_char !== want.has_char) begin
        $error("has_char: expected %b, got %b", want.has_char, got.has_char);
        errors++;
      end
      if (got.last !== want.last) begin
        $error("last: expected %b, got %b", want.last, got.last);
        errors++;
      end
    endfunction

    function int pending();
      return text_due.size();
    endfunction
  endclass

  logic                           clk       = 1'b0;
  logic                           rst_n     = 1'b0;
  logic                           cfg_wr_en = 1'b0;
  logic [sfr_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [sfr_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                           in_valid  = 1'b0;
  logic                           in_stall;
  sfr_pkg::sfr_in_t               in_data   = '0;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  sfr_pkg::sfr_out_t              out_data;

  bit idle_on  = 1'b1;
  bit hold_req = 1'b0;
  int quiet_cycles = 0;

  edit_stream book = new();

  stream_find_replace dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  task automatic write_cfg(input sfr_pkg::sfr_reg_t idx, input logic [63:0] v);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    book.write_reg(idx, v);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Offer one beat, with an optional idle burst first; returns just before the accepting edge.
  task automatic send_beat(input logic [7:0] c, input logic end_flag);
    sfr_pkg::sfr_in_t beat;
    int               gap;
    beat.ch     = c;
    beat.is_end = end_flag;
    gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 13) : 0;
    if (gap > 0) begin
      @(posedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(posedge clk);
    end
    @(posedge clk);
    in_valid <= 1'b1;
    in_data  <= beat;
    do @(negedge clk); while (in_stall !== 1'b0);
    book.accept_char(beat);
  endtask

  task automatic settle(input int extra);
    @(posedge clk);
    in_valid <= 1'b0;
    while (book.pending() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  always @(negedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      book.check_char(out_data);
    end
  end

  initial begin
    forever begin
      @(negedge clk);
      if ((in_valid === 1'b1 && in_stall === 1'b0) ||
          (out_valid === 1'b1 && out_stall === 1'b0)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 13)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  initial begin : stimulus
    logic [7:0]  pat_b [16];
    logic [7:0]  c;
    logic [4:0]  plen;
    logic [4:0]  rlen;
    logic [63:0] lo;
    logic [63:0] hi;
    int          eff;
    int          sent;
    int          r;
    int          n;
    int          bad;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // empty pattern: pass through, then end twice on an empty window
    send_beat("a", 1'b0);
    send_beat(8'hFF, 1'b0);
    send_beat(8'h00, 1'b0);
    send_beat(8'h5A, 1'b1);
    send_beat(8'hA5, 1'b1);
    settle(DRAIN_CYCLES);

    write_cfg(sfr_pkg::REG_PATTERN_LENGTH, 64'd3);
    write_cfg(sfr_pkg::REG_PATTERN_LOW, 64'h636261);
    write_cfg(sfr_pkg::REG_REPLACEMENT_LENGTH, 64'd2);
    write_cfg(sfr_pkg::REG_REPLACEMENT_LOW, 64'h5958);
    write_cfg(sfr_pkg::REG_IGNORE_CASE, 64'd0);
    send_beat("a", 1'b0);
    send_beat("b", 1'b0);
    send_beat("c", 1'b0);
    send_beat("A", 1'b0);
    send_beat("b", 1'b0);
    send_beat("c", 1'b0);
    send_beat("x", 1'b0);
    send_beat(8'h00, 1'b1);
    settle(DRAIN_CYCLES);

    // fold case, drop the match entirely, then shorten the pattern mid-string
    write_cfg(sfr_pkg::REG_IGNORE_CASE, 64'd1);
    write_cfg(sfr_pkg::REG_REPLACEMENT_LENGTH, 64'd0);
    send_beat("A", 1'b0);
    send_beat("B", 1'b0);
    send_beat("C", 1'b0);
    send_beat("a", 1'b0);
    send_beat("b", 1'b0);
    settle(DRAIN_CYCLES);
    write_cfg(sfr_pkg::REG_PATTERN_LENGTH, 64'd1);
    send_beat("a", 1'b0);
    send_beat(8'hFF, 1'b1);
    settle(DRAIN_CYCLES);

    for (int p = 0; p < PHASES; p++) begin
      idle_on = (p != 3 && p != PHASES - 1);
      case (p)
        0:       plen = 5'd16;
        1:       plen = 5'd31;
        2:       plen = 5'($urandom_range(2, 5));
        3:       plen = 5'd0;
        4:       plen = 5'd1;
        default: plen = 5'($urandom_range(1, 16));
      endcase
      case (p)
        0:       rlen = 5'd31;
        1:       rlen = 5'd0;
        2:       rlen = 5'($urandom_range(1, 4));
        3:       rlen = 5'd16;
        default: rlen = 5'($urandom_range(0, 16));
      endcase
      for (int k = 0; k < 16; k++) begin
        if ($urandom_range(0, 1) == 0) begin
          pat_b[k] = 8'($urandom_range(0, 255));
        end else begin
          pat_b[k] = 8'($urandom_range(8'h41, 8'h5A)) | ($urandom_range(0, 1) ? 8'h20 : 8'h00);
        end
        if (k < 8) begin
          lo[8*k +: 8] = pat_b[k];
        end else begin
          hi[8*(k-8) +: 8] = pat_b[k];
        end
      end
      write_cfg(sfr_pkg::REG_PATTERN_LENGTH, 64'(plen));
      write_cfg(sfr_pkg::REG_PATTERN_LOW, lo);
      write_cfg(sfr_pkg::REG_PATTERN_HIGH, hi);
      write_cfg(sfr_pkg::REG_REPLACEMENT_LENGTH, 64'(rlen));
      write_cfg(sfr_pkg::REG_REPLACEMENT_LOW, {$urandom, $urandom});
      write_cfg(sfr_pkg::REG_REPLACEMENT_HIGH, {$urandom, $urandom});
      write_cfg(sfr_pkg::REG_IGNORE_CASE, 64'(p % 2));
      eff = (plen > 16) ? 16 : int'(plen);
      if (p == 2) begin
        hold_req = 1'b1;
      end

      sent = 0;
      while (sent < PHASE_ITEMS) begin
        r = $urandom_range(0, 9);
        if (r <= 6 && eff > 0) begin
          n   = (r <= 4) ? eff : $urandom_range(1, eff);
          bad = ($urandom_range(0, 5) == 0) ? $urandom_range(0, n - 1) : -1;
          for (int k = 0; k < n; k++) begin
            c = pat_b[k];
            if ((c | 8'h20) >= "a" && (c | 8'h20) <= "z" && $urandom_range(0, 2) == 0) begin
              c = c ^ 8'h20;
            end
            if (k == bad) begin
              c = 8'($urandom_range(0, 255));
            end
            send_beat(c, 1'b0);
            sent++;
          end
        end else if (r == 9) begin
          send_beat(8'($urandom_range(0, 255)), 1'b1);
          sent++;
        end else begin
          repeat ($urandom_range(1, 3)) begin
            send_beat(8'($urandom_range(0, 255)), 1'b0);
            sent++;
          end
        end
      end
      send_beat(8'($urandom_range(0, 255)), 1'b1);
      settle(DRAIN_CYCLES);
    end

    settle(DRAIN_CYCLES);
    if (book.errors == 0 && book.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

@@ files.f @@
hdl/sfr_pkg.sv
hdl/sfr_dp.sv
hdl/sfr_ctrl.sv
hdl/stream_find_replace.sv
tb/sv/tb_stream_find_replace.sv
